>>> src/qrs_pkg.sv
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Result status codes shared by the front end and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

    typedef enum logic [2:0] {
        ST_LINEAR = 3'd0,
        ST_DOUBLE = 3'd1,
        ST_NONE   = 3'd2,
        ST_TWO    = 3'd3,
        ST_DEGEN  = 3'd4
    } status_t;

    localparam int OUT_FRAC = 16;

endpackage

`default_nettype wire

>>> src/qrs_front.sv
// ----------------------------------------------------------------------------
// Quadratic root solver front end
// Two register stages: the products b*b and a*c, then the discriminant, the
// case decision, the square root operand and the scaled numerator and divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_front #(
    parameter int W  = 16,
    parameter int SF = 15,
    parameter int DW = 34,
    parameter int XW = 64,
    parameter int NW = 34
) (
    input  wire logic                   aclk,
    input  wire logic                   en,
    input  wire logic signed [W-1:0]    coef_a,
    input  wire logic signed [W-1:0]    coef_b,
    input  wire logic signed [W-1:0]    coef_c,
    output logic [XW-1:0]               x_reg,
    output qrs_pkg::status_t            status_reg,
    output logic signed [NW-1:0]        base_reg,
    output logic signed [NW-1:0]        lin_reg,
    output logic signed [W+1:0]         den_reg
);
    import qrs_pkg::*;

    logic signed [W-1:0]     a1_reg;
    logic signed [W-1:0]     b1_reg;
    logic signed [W-1:0]     c1_reg;
    logic signed [2*W-1:0]   bb1_reg;
    logic signed [2*W-1:0]   ac1_reg;

    logic signed [2*W+1:0]   disc_full;
    logic signed [DW-1:0]    disc;
    logic [XW-1:0]           x_next;
    status_t                 status_next;
    logic signed [NW-1:0]    base_next;
    logic signed [NW-1:0]    lin_next;
    logic signed [W+1:0]     den_next;
    logic signed [NW-1:0]    b_ext;
    logic signed [NW-1:0]    c_ext;
    logic                    a_zero;
    logic                    b_zero;

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg  <= coef_a;
            b1_reg  <= coef_b;
            c1_reg  <= coef_c;
            bb1_reg <= coef_b * coef_b;
            ac1_reg <= coef_a * coef_c;
        end
    end

    always_comb begin
        disc_full = (2*W+2)'(bb1_reg) - ((2*W+2)'(ac1_reg) <<< 2);
        disc      = disc_full[DW-1:0];
        a_zero    = (a1_reg == '0);
        b_zero    = (b1_reg == '0);
        if (a_zero) begin
            status_next = b_zero ? ST_DEGEN : ST_LINEAR;
        end else if (disc == '0) begin
            status_next = ST_DOUBLE;
        end else if (disc[DW-1]) begin
            status_next = ST_NONE;
        end else begin
            status_next = ST_TWO;
        end
        x_next    = (status_next == ST_TWO) ? (XW'($unsigned(disc)) << (2*SF)) : '0;
        b_ext     = NW'(b1_reg);
        c_ext     = NW'(c1_reg);
        base_next = (-b_ext) <<< SF;
        lin_next  = a_zero ? ((-c_ext) <<< SF) : base_next;
        den_next  = a_zero ? (W+2)'(b1_reg) : ((W+2)'(a1_reg) <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg      <= x_next;
            status_reg <= status_next;
            base_reg   <= base_next;
            lin_reg    <= lin_next;
            den_reg    <= den_next;
        end
    end

endmodule

`default_nettype wire

>>> src/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Quadratic root solver square root cell
// One digit-by-digit step of the integer square root: two operand bits in,
// one root bit out.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt_cell #(
    parameter int XW = 64,
    parameter int RW = 32
) (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [XW-1:0]   x_in,
    input  wire logic [RW+1:0]   rem_in,
    input  wire logic [RW-1:0]   root_in,
    output logic [XW-1:0]        x_reg,
    output logic [RW+1:0]        rem_reg,
    output logic [RW-1:0]        root_reg
);

    logic [RW+1:0] shifted;
    logic [RW+1:0] trial;
    logic          fit;
    logic [XW-1:0] x_next;
    logic [RW+1:0] rem_next;
    logic [RW-1:0] root_next;

    always_comb begin
        shifted   = {rem_in[RW-1:0], x_in[XW-1:XW-2]};
        trial     = {root_in, 2'b01};
        fit       = (shifted >= trial);
        rem_next  = fit ? (shifted - trial) : shifted;
        root_next = {root_in[RW-2:0], fit};
        x_next    = x_in << 2;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

endmodule

`default_nettype wire

>>> src/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// Quadratic root solver divider cell
// One restoring division step: one dividend bit in, one quotient bit out.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div_cell #(
    parameter int NDW = 37,
    parameter int DVW = 18
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [DVW-1:0]   divisor,
    input  wire logic [NDW-1:0]   work_in,
    input  wire logic [DVW-1:0]   rem_in,
    output logic [NDW-1:0]        work_reg,
    output logic [DVW-1:0]        rem_reg
);

    logic [DVW:0]   trial;
    logic           fit;
    logic [DVW:0]   diff;
    logic [NDW-1:0] work_next;
    logic [DVW-1:0] rem_next;

    always_comb begin
        trial     = {rem_in, work_in[NDW-1]};
        fit       = (trial >= {1'b0, divisor});
        diff      = trial - {1'b0, divisor};
        rem_next  = fit ? diff[DVW-1:0] : trial[DVW-1:0];
        work_next = {work_in[NDW-2:0], fit};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

`default_nettype wire

>>> src/quadratic_root_solver_top.sv
// ----------------------------------------------------------------------------
// Quadratic root solver
// Real roots of a*x^2 + b*x + c = 0 for signed fixed-point coefficients,
// returned as saturated, rounded Q16.16 values with a status code.
//
// Usage: present a, b and c on the s_ channel with s_valid; every request
// produces exactly one result on the m_ channel (status, root_one, root_two).
// A result is taken when m_valid and m_ready are both high.
// Throughput is one request per cycle while the receiver does not stall. The
// pipeline stages are two front-end stages, RW square root cells (one root
// bit each), one divider setup stage, NDW divider cells (one quotient bit
// each) and the output register.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_ready drops; it resumes as soon as the result is taken.
// Reset empties the pipeline and clears m_valid; no request is lost or
// repeated across a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver_top #(
    parameter int COEF_WIDTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [COEF_WIDTH-1:0]   s_coef_a,
    input  wire logic signed [COEF_WIDTH-1:0]   s_coef_b,
    input  wire logic signed [COEF_WIDTH-1:0]   s_coef_c,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [2:0]                          m_status,
    output logic signed [31:0]                  m_root_one,
    output logic signed [31:0]                  m_root_two
);
    import qrs_pkg::*;

    localparam int W   = COEF_WIDTH;
    localparam int SF  = (W >= 31) ? 0 : (((31 - W) < 16) ? (31 - W) : 16);
    localparam int SH  = OUT_FRAC - SF;
    localparam int PW  = 2 * W + 2;
    localparam int DW  = (PW > 64) ? 64 : PW;
    localparam int XW  = DW + 2 * SF;
    localparam int RW  = XW / 2;
    localparam int NW  = ((RW > W + SF + 1) ? RW : (W + SF + 1)) + 2;
    localparam int NDW = NW + SH + 2;
    localparam int DVW = W + 2;
    localparam int QW  = (NDW > 33) ? NDW : 33;
    localparam int L   = 2 + RW + 1 + NDW;

    localparam logic [QW-1:0] POS_MAX = QW'(64'h0000_0000_7FFF_FFFF);
    localparam logic [QW-1:0] NEG_MAX = QW'(64'h0000_0000_8000_0000);

    function automatic logic [31:0] saturate(input logic [QW-1:0] q, input logic neg);
        logic [QW-1:0] nq;
        nq = -q;
        if (!neg) begin
            return (q > POS_MAX) ? 32'h7FFF_FFFF : q[31:0];
        end
        return (q > NEG_MAX) ? 32'h8000_0000 : nq[31:0];
    endfunction

    logic en;
    logic [L-1:0] vld_reg;
    logic [L-1:0] vld_next;

    logic                 m_valid_reg;
    status_t              m_status_reg;
    logic [31:0]          m_root_one_reg;
    logic [31:0]          m_root_two_reg;

    logic [XW-1:0]        sq_x      [0:RW];
    logic [RW+1:0]        sq_rem    [0:RW];
    logic [RW-1:0]        sq_root   [0:RW];
    status_t              sq_status [0:RW];
    logic signed [NW-1:0] sq_base   [0:RW];
    logic signed [NW-1:0] sq_lin    [0:RW];
    logic signed [W+1:0]  sq_den    [0:RW];

    logic [NDW-1:0]       dv_work1  [0:NDW];
    logic [DVW-1:0]       dv_rem1   [0:NDW];
    logic [NDW-1:0]       dv_work2  [0:NDW];
    logic [DVW-1:0]       dv_rem2   [0:NDW];
    logic [DVW-1:0]       dv_dvs    [0:NDW];
    status_t              dv_status [0:NDW];
    logic                 dv_neg1   [0:NDW];
    logic                 dv_neg2   [0:NDW];

    logic signed [NW-1:0] num1;
    logic signed [NW-1:0] num2;
    logic [NW-1:0]        mag1;
    logic [NW-1:0]        mag2;
    logic [W+1:0]         dmag;
    logic signed [W+1:0]  den_last;

    logic [31:0]          root_one_next;
    logic [31:0]          root_two_next;

    assign en         = !m_valid_reg || m_ready;
    assign s_ready    = en;
    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_root_one = m_root_one_reg;
    assign m_root_two = m_root_two_reg;

    assign vld_next = {vld_reg[L-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= vld_next;
            m_valid_reg <= vld_reg[L-1];
        end
    end

    qrs_front #(
        .W  (W),
        .SF (SF),
        .DW (DW),
        .XW (XW),
        .NW (NW)
    ) u_front (
        .aclk       (aclk),
        .en         (en),
        .coef_a     (s_coef_a),
        .coef_b     (s_coef_b),
        .coef_c     (s_coef_c),
        .x_reg      (sq_x[0]),
        .status_reg (sq_status[0]),
        .base_reg   (sq_base[0]),
        .lin_reg    (sq_lin[0]),
        .den_reg    (sq_den[0])
    );

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        qrs_sqrt_cell #(
            .XW (XW),
            .RW (RW)
        ) u_cell (
            .aclk     (aclk),
            .en       (en),
            .x_in     (sq_x[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .x_reg    (sq_x[k+1]),
            .rem_reg  (sq_rem[k+1]),
            .root_reg (sq_root[k+1])
        );

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_status[k+1] <= sq_status[k];
                sq_base[k+1]   <= sq_base[k];
                sq_lin[k+1]    <= sq_lin[k];
                sq_den[k+1]    <= sq_den[k];
            end
        end
    end

    always_comb begin
        den_last = sq_den[RW];
        num1 = (sq_status[RW] == ST_TWO)
             ? (sq_base[RW] + NW'({1'b0, sq_root[RW]})) : sq_lin[RW];
        num2 = sq_base[RW] - NW'({1'b0, sq_root[RW]});
        mag1 = num1[NW-1] ? (-num1) : num1;
        mag2 = num2[NW-1] ? (-num2) : num2;
        dmag = den_last[W+1] ? (-den_last) : den_last;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_work1[0]  <= (NDW'(mag1) << (SH + 1)) + NDW'(dmag);
            dv_work2[0]  <= (NDW'(mag2) << (SH + 1)) + NDW'(dmag);
            dv_dvs[0]    <= DVW'(dmag) << 1;
            dv_status[0] <= sq_status[RW];
            dv_neg1[0]   <= num1[NW-1] ^ den_last[W+1];
            dv_neg2[0]   <= num2[NW-1] ^ den_last[W+1];
        end
    end

    assign dv_rem1[0] = '0;
    assign dv_rem2[0] = '0;

    for (genvar k = 0; k < NDW; k++) begin : g_div
        qrs_div_cell #(
            .NDW (NDW),
            .DVW (DVW)
        ) u_lane1 (
            .aclk     (aclk),
            .en       (en),
            .divisor  (dv_dvs[k]),
            .work_in  (dv_work1[k]),
            .rem_in   (dv_rem1[k]),
            .work_reg (dv_work1[k+1]),
            .rem_reg  (dv_rem1[k+1])
        );

        qrs_div_cell #(
            .NDW (NDW),
            .DVW (DVW)
        ) u_lane2 (
            .aclk     (aclk),
            .en       (en),
            .divisor  (dv_dvs[k]),
            .work_in  (dv_work2[k]),
            .rem_in   (dv_rem2[k]),
            .work_reg (dv_work2[k+1]),
            .rem_reg  (dv_rem2[k+1])
        );

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_dvs[k+1]    <= dv_dvs[k];
                dv_status[k+1] <= dv_status[k];
                dv_neg1[k+1]   <= dv_neg1[k];
                dv_neg2[k+1]   <= dv_neg2[k];
            end
        end
    end

    always_comb begin
        case (dv_status[NDW]) inside
            ST_LINEAR, ST_DOUBLE: begin
                root_one_next = saturate(QW'(dv_work1[NDW]), dv_neg1[NDW]);
                root_two_next = '0;
            end
            ST_TWO: begin
                root_one_next = saturate(QW'(dv_work1[NDW]), dv_neg1[NDW]);
                root_two_next = saturate(QW'(dv_work2[NDW]), dv_neg2[NDW]);
            end
            default: begin
                root_one_next = '0;
                root_two_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_status_reg   <= dv_status[NDW];
            m_root_one_reg <= root_one_next;
            m_root_two_reg <= root_two_next;
        end
    end

    a_no_roots_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_NONE || m_status == ST_DEGEN)
        |-> (m_root_one == '0) && (m_root_two == '0))
        else $error("roots not zero for a result without roots");

    a_single_root_two_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_LINEAR || m_status == ST_DOUBLE)
        |-> (m_root_two == '0))
        else $error("second root not zero for a single-root result");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ST_DEGEN))
        else $error("result status out of range");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(vld_reg))
        else $error("pipeline advanced while the result was stalled");

endmodule

`default_nettype wire
